// File: rtl/blli_pkg.sv
// Shared types, constants and codes of the battery level LED indicator.
`timescale 1ns / 1ps
`default_nettype none

package blli_pkg;

    // Field widths
    localparam int unsigned VOLT_W      = 16;
    localparam int unsigned SUM_W       = 32;
    localparam int unsigned LEVEL_W     = 2;
    localparam int unsigned PINS_W      = 3;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned DIV_STEPS   = SUM_W;
    localparam int unsigned STEP_W      = $clog2(DIV_STEPS);

    // Configuration reset values
    localparam logic [VOLT_W-1:0] RST_THRESHOLD  = 16'd3700;
    localparam logic [VOLT_W-1:0] RST_AVG_LENGTH = 16'd1000;
    localparam logic [VOLT_W-1:0] RST_HOLD_TICKS = 16'd5000;
    localparam logic [VOLT_W-1:0] RST_BLINK      = 16'd500;

    // Pin positions inside the LED pin vector (active low)
    localparam int unsigned PIN_LOW_BIT   = 0;
    localparam int unsigned PIN_RED_BIT   = 1;
    localparam int unsigned PIN_GREEN_BIT = 2;
    localparam logic [PINS_W-1:0] PINS_ALL_OFF = 3'b111;
    localparam logic [PINS_W-1:0] PINS_CHARGED = 3'b011;

    // Level classes
    localparam logic [LEVEL_W-1:0] LVL_UNKNOWN  = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_UNDER75  = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_UNDER100 = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_CHARGED  = 2'd3;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD   = 3'd0,
        CFG_CHG_OFFSET  = 3'd1,
        CFG_LED_OFFSET  = 3'd2,
        CFG_AUD_OFFSET  = 3'd3,
        CFG_AVG_LENGTH  = 3'd4,
        CFG_HOLD_TICKS  = 3'd5,
        CFG_BLINK_TICKS = 3'd6
    } t_cfg_idx;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;    // latch the accepted beat
        logic acc;        // correct, accumulate, tick timers down
        logic mean_zero;  // mean due with zero count: mean is 0
        logic div_load;   // start the divider, clear the accumulator
        logic div_step;   // one divider step
        logic div_last;   // final step, write the mean
        logic finish;     // classify, drive LEDs, load the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic due;        // sample count has reached the average length
        logic cnt_zero;   // sample count is zero
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/battery_level_led_indicator.sv
// Battery level LED indicator: one beat in per millisecond tick, one beat out.
// Steps: latch the beat, accumulate, check whether a mean is due and, when it is,
// run the 32-step divider at one bit per cycle, then finish into the output register.
// A new beat is taken only once the last one has been finished.
// The input side reopens while a finished result still waits on the output.
// Reset (i_rst_n low, synchronous): configuration to defaults, LED state off, level unknown; output register not reset.
`timescale 1ns / 1ps
`default_nettype none

module battery_level_led_indicator (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // sample_voltage[15:0], supply_present[16], lamp_load_on[17],
    // audio_load_on[18], charger_detected[19], zero fill [23:20]
    input  wire logic [blli_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // pin_low_level[0], pin_red[1], pin_green[2], shown_level[4:3],
    // average_voltage[20:5], zero fill [23:21]
    output logic [blli_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [blli_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [blli_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import blli_pkg::*;

    t_cmd               w_cmd;
    t_sts               w_sts;
    logic [PINS_W-1:0]  w_pins;
    logic [LEVEL_W-1:0] w_level;
    logic [VOLT_W-1:0]  w_mean;

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;

    // Controller
    blli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath
    blli_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_sample_voltage   (s_axis_tdata[VOLT_W-1:0]),
        .i_supply_present   (s_axis_tdata[VOLT_W]),
        .i_lamp_load_on     (s_axis_tdata[VOLT_W+1]),
        .i_audio_load_on    (s_axis_tdata[VOLT_W+2]),
        .i_charger_detected (s_axis_tdata[VOLT_W+3]),
        .o_pins             (w_pins),
        .o_shown_level      (w_level),
        .o_average_voltage  (w_mean)
    );

    // Output beat packing
    assign m_axis_tdata = {(OUT_TDATA_W - PINS_W - LEVEL_W - VOLT_W)'(0),
                           w_mean, w_level, w_pins};

    // The block takes no second beat straight after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // Unknown level keeps every LED dark
    a_unknown_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_level == LVL_UNKNOWN) |-> (w_pins == PINS_ALL_OFF))
        else $error("LED lit with unknown level");

    // Charged level shows green alone
    a_charged_green: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_level == LVL_CHARGED) |-> (w_pins == PINS_CHARGED))
        else $error("charged level with wrong LED pattern");

    // A stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");

endmodule

`default_nettype wire

// File: rtl/blli_ctrl.sv
// Sequencing state machine of the battery level LED indicator.
`timescale 1ns / 1ps
`default_nettype none

module blli_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    input  wire blli_pkg::t_sts i_sts,
    output blli_pkg::t_cmd     o_cmd
);
    import blli_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ACC  = 5'b00010,
        S_CHK  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                n_step = '0;
                priority if (!i_sts.due) begin
                    n_state = S_FIN;
                end else if (i_sts.cnt_zero) begin
                    o_cmd.mean_zero = 1'b1;
                    n_state         = S_FIN;
                end else begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    o_cmd.div_last = 1'b1;
                    n_state        = S_FIN;
                end
            end
            S_FIN: begin
                // wait until the output register can take the result
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: rtl/blli_dp.sv
// Datapath: configuration, sample averaging, divider, level hold and LED drive.
`timescale 1ns / 1ps
`default_nettype none

module blli_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire blli_pkg::t_cmd                   i_cmd,
    output blli_pkg::t_sts                        o_sts,
    input  wire logic                             i_cfg_we,
    input  wire logic [blli_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [blli_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic [blli_pkg::VOLT_W-1:0]      i_sample_voltage,
    input  wire logic                             i_supply_present,
    input  wire logic                             i_lamp_load_on,
    input  wire logic                             i_audio_load_on,
    input  wire logic                             i_charger_detected,
    output logic [blli_pkg::PINS_W-1:0]           o_pins,
    output logic [blli_pkg::LEVEL_W-1:0]          o_shown_level,
    output logic [blli_pkg::VOLT_W-1:0]           o_average_voltage
);
    import blli_pkg::*;

    // Configuration registers
    logic [VOLT_W-1:0] r_threshold, r_chg_off, r_led_off, r_aud_off;
    logic [VOLT_W-1:0] r_avg_len, r_hold_ticks, r_blink_ticks;

    // Latched beat
    logic [VOLT_W-1:0] r_in_volt;
    logic              r_in_supply, r_in_lamp, r_in_audio, r_in_charger;

    // Running state
    logic [VOLT_W-1:0]  r_count, r_mean, r_hold, r_blow, r_bred;
    logic [SUM_W-1:0]   r_sum;
    logic [LEVEL_W-1:0] r_seen, r_disp;
    logic [PINS_W-1:0]  r_pins;

    // Divider
    logic [SUM_W-1:0]  r_dvd;
    logic [VOLT_W-1:0] r_dvsr, r_rem, r_quot;
    logic [VOLT_W:0]   w_trial, w_diff;
    logic              w_qbit;
    logic [VOLT_W-1:0] n_rem, n_quot;

    // Output register
    logic [PINS_W-1:0]  r_o_pins;
    logic [LEVEL_W-1:0] r_o_level;
    logic [VOLT_W-1:0]  r_o_mean;

    // Combinational results
    logic [VOLT_W-1:0]  w_corr;
    logic [LEVEL_W-1:0] w_cls, n_seen, n_disp;
    logic [VOLT_W-1:0]  n_hold, n_blow, n_bred;
    logic [PINS_W-1:0]  n_pins;

    assign o_sts.due      = (r_count >= r_avg_len);
    assign o_sts.cnt_zero = (r_count == '0);

    assign o_pins            = r_o_pins;
    assign o_shown_level     = r_o_level;
    assign o_average_voltage = r_o_mean;

    // Sample correction, wraps at 16 bits
    always_comb begin
        if (r_in_supply) begin
            w_corr = r_in_volt - r_chg_off;
        end else begin
            w_corr = r_in_volt + (r_in_lamp ? r_led_off : '0)
                               + (r_in_audio ? r_aud_off : '0);
        end
    end

    // One restoring division step
    assign w_trial = {r_rem, r_dvd[SUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvsr};
    assign w_qbit  = !w_diff[VOLT_W];
    assign n_rem   = w_qbit ? w_diff[VOLT_W-1:0] : w_trial[VOLT_W-1:0];
    assign n_quot  = {r_quot[VOLT_W-2:0], w_qbit};

    // Classification, hold and LED update
    always_comb begin
        priority if (r_in_charger) begin
            w_cls = LVL_CHARGED;
        end else if (r_mean < r_threshold) begin
            w_cls = LVL_UNDER75;
        end else begin
            w_cls = LVL_UNDER100;
        end

        n_seen = r_seen;
        n_disp = r_disp;
        n_hold = r_hold;
        n_blow = r_blow;
        n_bred = r_bred;
        n_pins = r_pins;

        priority if (r_seen == LVL_UNKNOWN) begin
            n_seen = w_cls;
            n_disp = w_cls;
        end else if (r_seen != w_cls) begin
            n_seen = w_cls;
            n_hold = r_hold_ticks;
        end
        if (n_disp != n_seen && n_hold == '0) begin
            n_disp = n_seen;
        end

        unique case (n_disp)
            LVL_UNDER75: begin
                if (r_blow == '0) begin
                    n_blow = r_blink_ticks;
                    n_pins = PINS_ALL_OFF;
                    n_pins[PIN_LOW_BIT] = !r_pins[PIN_LOW_BIT];
                end
            end
            LVL_UNDER100: begin
                if (r_bred == '0) begin
                    n_bred = r_blink_ticks;
                    n_pins = PINS_ALL_OFF;
                    n_pins[PIN_LOW_BIT] = 1'b0;
                    n_pins[PIN_RED_BIT] = !r_pins[PIN_RED_BIT];
                end
            end
            LVL_CHARGED: begin
                n_pins = PINS_CHARGED;
            end
            LVL_UNKNOWN: begin
                n_pins = PINS_ALL_OFF;
            end
            default: begin
                n_pins = PINS_ALL_OFF;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= RST_THRESHOLD;
            r_chg_off     <= '0;
            r_led_off     <= '0;
            r_aud_off     <= '0;
            r_avg_len     <= RST_AVG_LENGTH;
            r_hold_ticks  <= RST_HOLD_TICKS;
            r_blink_ticks <= RST_BLINK;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_THRESHOLD:   r_threshold   <= i_cfg_data;
                CFG_CHG_OFFSET:  r_chg_off     <= i_cfg_data;
                CFG_LED_OFFSET:  r_led_off     <= i_cfg_data;
                CFG_AUD_OFFSET:  r_aud_off     <= i_cfg_data;
                CFG_AVG_LENGTH:  r_avg_len     <= i_cfg_data;
                CFG_HOLD_TICKS:  r_hold_ticks  <= i_cfg_data;
                CFG_BLINK_TICKS: r_blink_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input beat latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_volt    <= i_sample_voltage;
            r_in_supply  <= i_supply_present;
            r_in_lamp    <= i_lamp_load_on;
            r_in_audio   <= i_audio_load_on;
            r_in_charger <= i_charger_detected;
        end
    end

    // Divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dvd  <= r_sum;
            r_dvsr <= r_count;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[SUM_W-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    // Accumulator, timers, mean and level state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_mean  <= '0;
            r_seen  <= LVL_UNKNOWN;
            r_disp  <= LVL_UNKNOWN;
            r_hold  <= '0;
            r_blow  <= '0;
            r_bred  <= '0;
            r_pins  <= PINS_ALL_OFF;
        end else begin
            if (i_cmd.acc) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + SUM_W'(w_corr);
                if (r_hold != '0) r_hold <= r_hold - 1'b1;
                if (r_blow != '0) r_blow <= r_blow - 1'b1;
                if (r_bred != '0) r_bred <= r_bred - 1'b1;
            end
            if (i_cmd.mean_zero || i_cmd.div_load) begin
                r_count <= '0;
                r_sum   <= '0;
            end
            if (i_cmd.mean_zero) begin
                r_mean <= '0;
            end
            if (i_cmd.div_last) begin
                r_mean <= n_quot;
            end
            if (i_cmd.finish) begin
                r_seen <= n_seen;
                r_disp <= n_disp;
                r_hold <= n_hold;
                r_blow <= n_blow;
                r_bred <= n_bred;
                r_pins <= n_pins;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_pins  <= n_pins;
            r_o_level <= n_disp;
            r_o_mean  <= r_mean;
        end
    end

endmodule

`default_nettype wire
